// File: rtl/ile_pkg.sv
package ile_pkg;

  // Default sizes of the list.
  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  // Fixed field widths.
  localparam int CMD_BITS    = 3;
  localparam int STATUS_BITS = 2;

  // Command codes carried by an input item.
  typedef enum logic [CMD_BITS-1:0] {
    CMD_APPEND    = 3'd0,
    CMD_REMOVE    = 3'd1,
    CMD_READ      = 3'd2,
    CMD_INSERT    = 3'd3,
    CMD_OVERWRITE = 3'd4,
    CMD_FIND      = 3'd5
  } cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What a cell loads into its stored word.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_ZERO,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_t;

  // Control handed to every cell in a cycle.
  typedef struct packed {
    cell_op_t op;
    logic     scan_load;
    logic     scan_shift;
  } cell_ctl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT
  } state_t;

endpackage

// File: rtl/ile_cell.sv
module ile_cell #(
  parameter int WORD_BITS = ile_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  ile_pkg::cell_ctl_t    ctl,
  input  logic [WORD_BITS-1:0]  value,
  input  logic [WORD_BITS-1:0]  left_word,
  input  logic [WORD_BITS-1:0]  right_word,
  input  logic [WORD_BITS-1:0]  right_scan,
  output logic [WORD_BITS-1:0]  word,
  output logic [WORD_BITS-1:0]  scan
);

  // Stored list entry: written, cleared, or taken from a neighbor when the list shifts.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      ile_pkg::CELL_WRITE:      word <= value;
      ile_pkg::CELL_ZERO:       word <= '0;
      ile_pkg::CELL_FROM_LEFT:  word <= left_word;
      ile_pkg::CELL_FROM_RIGHT: word <= right_word;
      default:                  word <= word;
    endcase
  end

  // Scan stage: snapshots the entry; on scan_shift moves one cell toward the head per cycle.
  always_ff @(posedge clk) begin
    if (ctl.scan_load) begin
      scan <= word;
    end else if (ctl.scan_shift) begin
      scan <= right_scan;
    end
  end

endmodule

// File: rtl/indexed_list_engine.sv
// Ordered list of up to DEPTH words held in a row of cells, one entry per cell.
// Append, insert, overwrite and every failing command finish in the cycle the
// item is accepted: all cells shift, write or zero-fill at once, and the next
// item can follow in the next cycle if the output register is free. Read and
// remove at resolved index k end when the scan reaches k; find ends at the
// first match or, if the value is absent, at count. On acceptance the list
// is copied into the scan line, which moves one cell toward the head each
// cycle; only the head cell is read and compared. A result waits in the
// output register while the next item is accepted; in_stall is high while a
// scan runs or while a finished result cannot yet enter the output register.
module indexed_list_engine #(
  parameter int  DEPTH     = ile_pkg::DEPTH_DEF,
  parameter int  WORD_BITS = ile_pkg::WORD_BITS_DEF,
  localparam int IB        = $clog2(DEPTH) + 1,
  localparam int CB        = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ile_pkg::CMD_BITS-1:0] command,
  input  logic signed [IB-1:0]         position,
  input  logic signed [WORD_BITS-1:0]  value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [WORD_BITS-1:0]  read_value,
  output logic signed [IB-1:0]         found_index,
  output logic [ile_pkg::STATUS_BITS-1:0] status,
  output logic [CB-1:0]                count,
  output logic                         empty_res
);

  localparam logic [IB-1:0] IDX_ONE   = IB'(1);
  localparam logic [IB-1:0] IDX_LIMIT = IB'(DEPTH);
  localparam logic [CB-1:0] CNT_ONE   = CB'(1);
  localparam logic [CB-1:0] CNT_MAX   = CB'(DEPTH);

  ile_pkg::state_t state, state_next;

  logic [CB-1:0]        entry_count;
  logic [CB-1:0]        scan_pos;
  logic [CB-1:0]        scan_target;
  logic                 scan_find;
  logic [WORD_BITS-1:0] key;

  logic in_fire;
  logic out_free;

  logic [WORD_BITS-1:0] words [DEPTH];
  logic [WORD_BITS-1:0] scans [DEPTH];

  // Position resolution: negative positions count back from the end.
  logic          pos_neg;
  logic [IB-1:0] cnt_x;
  logic [IB-1:0] back;
  logic [IB-1:0] idx;
  logic          pos_ok;
  logic          in_list;
  logic          ext_fits;
  logic          list_full;

  assign pos_neg   = position[IB-1];
  assign cnt_x     = IB'(entry_count);
  assign back      = IDX_ONE + $unsigned(~position);
  assign pos_ok    = !pos_neg || (back <= cnt_x);
  assign idx       = pos_neg ? (cnt_x - back) : $unsigned(position);
  assign in_list   = pos_ok && (idx < cnt_x);
  assign ext_fits  = idx < IDX_LIMIT;
  assign list_full = entry_count == CNT_MAX;

  // Command decode for the item on the input port.
  logic              go_append;
  logic              go_down;
  logic              go_up;
  logic              go_write;
  logic              go_zero;
  logic              go_scan;
  logic              scan_is_find;
  ile_pkg::status_t  imm_status;
  logic [CB-1:0]     cnt_after;

  always_comb begin
    go_append    = 1'b0;
    go_down      = 1'b0;
    go_up        = 1'b0;
    go_write     = 1'b0;
    go_zero      = 1'b0;
    go_scan      = 1'b0;
    scan_is_find = 1'b0;
    imm_status   = ile_pkg::ST_OK;
    cnt_after    = entry_count;
    unique case (ile_pkg::cmd_t'(command))
      ile_pkg::CMD_APPEND: begin
        if (list_full) begin
          imm_status = ile_pkg::ST_FULL;
        end else begin
          go_append = 1'b1;
          cnt_after = entry_count + CNT_ONE;
        end
      end
      ile_pkg::CMD_REMOVE: begin
        if (!in_list) begin
          imm_status = ile_pkg::ST_RANGE;
        end else begin
          go_down   = 1'b1;
          go_scan   = 1'b1;
          cnt_after = entry_count - CNT_ONE;
        end
      end
      ile_pkg::CMD_READ: begin
        if (!in_list) begin
          imm_status = ile_pkg::ST_RANGE;
        end else begin
          go_scan = 1'b1;
        end
      end
      ile_pkg::CMD_INSERT: begin
        if (!pos_ok) begin
          imm_status = ile_pkg::ST_RANGE;
        end else if (!in_list) begin
          if (ext_fits) begin
            go_zero   = 1'b1;
            go_write  = 1'b1;
            cnt_after = CB'(idx + IDX_ONE);
          end else begin
            imm_status = ile_pkg::ST_FULL;
          end
        end else if (list_full) begin
          imm_status = ile_pkg::ST_FULL;
        end else begin
          go_up     = 1'b1;
          go_write  = 1'b1;
          cnt_after = entry_count + CNT_ONE;
        end
      end
      ile_pkg::CMD_OVERWRITE: begin
        if (!pos_ok) begin
          imm_status = ile_pkg::ST_RANGE;
        end else if (!in_list) begin
          if (ext_fits) begin
            go_zero   = 1'b1;
            go_write  = 1'b1;
            cnt_after = CB'(idx + IDX_ONE);
          end else begin
            imm_status = ile_pkg::ST_FULL;
          end
        end else begin
          go_write = 1'b1;
        end
      end
      ile_pkg::CMD_FIND: begin
        go_scan      = 1'b1;
        scan_is_find = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Row of cells; each one decides its own move from its fixed index.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [IB-1:0] CI = IB'(i);

    ile_pkg::cell_ctl_t   ctl;
    logic [WORD_BITS-1:0] left_word;
    logic [WORD_BITS-1:0] right_word;
    logic [WORD_BITS-1:0] right_scan;

    always_comb begin
      ctl.op         = ile_pkg::CELL_HOLD;
      ctl.scan_load  = in_fire && go_scan;
      ctl.scan_shift = state == ile_pkg::S_SCAN;
      if (in_fire) begin
        if (go_append && (CI == cnt_x)) begin
          ctl.op = ile_pkg::CELL_WRITE;
        end else if (go_write && (CI == idx)) begin
          ctl.op = ile_pkg::CELL_WRITE;
        end else if (go_zero && (CI >= cnt_x) && (CI < idx)) begin
          ctl.op = ile_pkg::CELL_ZERO;
        end else if (go_up && (CI > idx)) begin
          ctl.op = ile_pkg::CELL_FROM_LEFT;
        end else if (go_down && (CI >= idx)) begin
          ctl.op = ile_pkg::CELL_FROM_RIGHT;
        end
      end
    end

    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_inner_left
      assign left_word = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = '0;
      assign right_scan = '0;
    end else begin : g_inner_right
      assign right_word = words[i+1];
      assign right_scan = scans[i+1];
    end

    ile_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .value      (value),
      .left_word  (left_word),
      .right_word (right_word),
      .right_scan (right_scan),
      .word       (words[i]),
      .scan       (scans[i])
    );
  end

  // Head of the scan line: the entry at scan_pos.
  logic          head_match;
  logic          scan_end;
  logic [IB-1:0] scan_fi;

  assign head_match = (scan_pos != entry_count) && (scans[0] == key);
  assign scan_end   = scan_find ? ((scan_pos == entry_count) || head_match)
                                : (scan_pos == scan_target);
  assign scan_fi    = head_match ? IB'(scan_pos) : '1;

  // Result staging.
  logic                 res_ready;
  logic [WORD_BITS-1:0] res_rv;
  logic [IB-1:0]        res_fi;
  ile_pkg::status_t     res_st;
  logic [CB-1:0]        res_cnt;

  logic [WORD_BITS-1:0] pend_rv;
  logic [IB-1:0]        pend_fi;
  ile_pkg::status_t     pend_st;
  logic [CB-1:0]        pend_cnt;

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ile_pkg::S_IDLE: begin
        if (in_fire) begin
          if (go_scan) begin
            state_next = ile_pkg::S_SCAN;
          end else if (!out_free) begin
            state_next = ile_pkg::S_WAIT;
          end
        end
      end
      ile_pkg::S_SCAN: begin
        if (scan_end) begin
          state_next = out_free ? ile_pkg::S_IDLE : ile_pkg::S_WAIT;
        end
      end
      ile_pkg::S_WAIT: begin
        if (out_free) begin
          state_next = ile_pkg::S_IDLE;
        end
      end
      default: state_next = ile_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: input stall and the finished result.
  always_comb begin
    in_stall  = state != ile_pkg::S_IDLE;
    res_ready = 1'b0;
    res_rv    = '0;
    res_fi    = '0;
    res_st    = ile_pkg::ST_OK;
    res_cnt   = entry_count;
    unique case (state)
      ile_pkg::S_IDLE: begin
        res_ready = in_fire && !go_scan;
        res_st    = imm_status;
        res_cnt   = cnt_after;
      end
      ile_pkg::S_SCAN: begin
        res_ready = scan_end;
        res_rv    = scan_find ? '0 : scans[0];
        res_fi    = scan_find ? scan_fi : '0;
      end
      ile_pkg::S_WAIT: begin
        res_ready = 1'b1;
        res_rv    = pend_rv;
        res_fi    = pend_fi;
        res_st    = pend_st;
        res_cnt   = pend_cnt;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ile_pkg::S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        entry_count <= cnt_after;
      end
      if (res_ready && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scan bookkeeping and result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key         <= value;
      scan_target <= CB'(idx);
      scan_find   <= scan_is_find;
      scan_pos    <= '0;
    end else if (state == ile_pkg::S_SCAN) begin
      scan_pos <= scan_pos + CNT_ONE;
    end
    if (res_ready && out_free) begin
      read_value  <= res_rv;
      found_index <= res_fi;
      status      <= res_st;
      count       <= res_cnt;
      empty_res   <= res_cnt == '0;
    end else if (res_ready) begin
      pend_rv  <= res_rv;
      pend_fi  <= res_fi;
      pend_st  <= res_st;
      pend_cnt <= res_cnt;
    end
  end

endmodule

// File: rtl/ile_checker.sv
module ile_checker #(
  parameter int  DEPTH     = ile_pkg::DEPTH_DEF,
  parameter int  WORD_BITS = ile_pkg::WORD_BITS_DEF,
  localparam int IB        = $clog2(DEPTH) + 1,
  localparam int CB        = $clog2(DEPTH + 1)
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [WORD_BITS-1:0]     read_value,
  input logic signed [IB-1:0]            found_index,
  input logic [ile_pkg::STATUS_BITS-1:0] status,
  input logic [CB-1:0]                   count,
  input logic                            empty_res
);

  localparam logic [CB-1:0] CNT_MAX = CB'(DEPTH);

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_value) &&
      $stable(found_index) && $stable(status) && $stable(count))
    else $error("result changed while stalled");

  // The empty flag agrees with the count it travels with.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (empty_res == (count == '0)))
    else $error("empty flag disagrees with count");

  // The list never grows past its capacity.
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count <= CNT_MAX))
    else $error("count beyond capacity");

  // A failed command returns no data and no index.
  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ile_pkg::ST_OK) |-> (read_value == '0) && (found_index == '0))
    else $error("failed command returned data");

  // The block takes items right after reset.
  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !in_stall)
    else $error("input stalled after reset");

endmodule

bind indexed_list_engine ile_checker #(
  .DEPTH     (DEPTH),
  .WORD_BITS (WORD_BITS)
) u_ile_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .read_value  (read_value),
  .found_index (found_index),
  .status      (status),
  .count       (count),
  .empty_res   (empty_res)
);
